// File: src/hwfm_pkg.sv
`default_nettype none

package hwfm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 10;
  localparam int MAG_W    = 25;
  localparam int HANN_W   = 16;
  localparam int TW_W     = 18;
  localparam int WORK_W   = 28;
  localparam int SQ_W     = 57;
  localparam int SQRT_W   = 58;
  localparam int ROOT_W   = 29;
  localparam int ISQ_TOP  = 56;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic signed [WORK_W-1:0] WORK_MAX = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic signed [WORK_W-1:0] WORK_MIN = {1'b1, {(WORK_W-1){1'b0}}};

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic smp_wr;
    logic out_load;
    logic win_rd;
    logic work_rd;
    logic bf_mul;
    logic bf_sum;
    logic bf_add;
    logic wr_a;
    logic wr_b;
    logic mag_sq;
    logic sqrt_start;
    logic spec_wr;
  } hwfm_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
  } hwfm_status_t;

  // Q30 series used only to build the coefficient tables at elaboration
  function automatic longint cos_series(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = ONE_Q30;
    sum  = ONE_Q30;
    term = ((term * x2) >>> 30) / 2;   sum = sum - term;
    term = ((term * x2) >>> 30) / 12;  sum = sum + term;
    term = ((term * x2) >>> 30) / 30;  sum = sum - term;
    term = ((term * x2) >>> 30) / 56;  sum = sum + term;
    term = ((term * x2) >>> 30) / 90;  sum = sum - term;
    term = ((term * x2) >>> 30) / 132; sum = sum + term;
    term = ((term * x2) >>> 30) / 182; sum = sum - term;
    return sum;
  endfunction

  function automatic longint sin_series(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    term = ((term * x2) >>> 30) / 210; sum = sum - term;
    return sum;
  endfunction

  function automatic longint turn_to_rad(input logic [31:0] t);
    longint unsigned p;
    p = ({32'd0, t} * PI_Q30 + (64'd1 << 30)) >> 31;
    return longint'(p);
  endfunction

  // cos(2*pi*t/2^32) in Q30
  function automatic longint cos_turn(input logic [31:0] t);
    logic [31:0] u;
    logic        neg;
    longint      r;
    u   = t;
    neg = 1'b0;
    if (u > 32'h8000_0000) u = 32'h0 - u;
    if (u > 32'h4000_0000) begin
      u   = 32'h8000_0000 - u;
      neg = 1'b1;
    end
    if (u > 32'h2000_0000) r = sin_series(turn_to_rad(32'h4000_0000 - u));
    else r = cos_series(turn_to_rad(u));
    return neg ? -r : r;
  endfunction

  function automatic longint q30_to_q17(input longint c);
    return ((c + ONE_Q30 + 64'sd4096) >>> 13) - 64'sd131072;
  endfunction

  function automatic logic [HANN_W-1:0] clamp_hann(input longint h);
    if (h < 0) return '0;
    if (h > 64'sd32767) return HANN_W'(32767);
    return HANN_W'(h);
  endfunction

  function automatic logic [TW_W-1:0] clamp_tw(input longint v);
    if (v < -64'sd131072) return TW_W'(-131072);
    if (v > 64'sd131071) return TW_W'(131071);
    return TW_W'(v);
  endfunction

  function automatic logic signed [WORK_W-1:0] sat_work(input logic signed [WORK_W+2:0] v);
    if (v > (WORK_W+3)'(WORK_MAX)) return WORK_MAX;
    if (v < (WORK_W+3)'(WORK_MIN)) return WORK_MIN;
    return v[WORK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/hwfm_isqrt.sv
`default_nettype none

module hwfm_isqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [hwfm_pkg::SQ_W-1:0]      operand,
  output logic                                busy,
  output logic [hwfm_pkg::ROOT_W-1:0]         root
);

  logic                          busy_r;
  logic [hwfm_pkg::SQRT_W-1:0]   val_r;
  logic [hwfm_pkg::SQRT_W-1:0]   root_r;
  logic [hwfm_pkg::SQRT_W-1:0]   bit_r;
  logic [hwfm_pkg::SQRT_W-1:0]   trial;

  assign trial = root_r + bit_r;
  assign busy  = busy_r;
  assign root  = root_r[hwfm_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  // one result bit per cycle, two operand bits consumed per step
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= hwfm_pkg::SQRT_W'(operand);
      root_r <= '0;
      bit_r  <= hwfm_pkg::SQRT_W'(1) << hwfm_pkg::ISQ_TOP;
    end else if (busy_r) begin
      if (val_r >= trial) begin
        val_r  <= val_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

`default_nettype wire

// File: src/hwfm_dp.sv
`default_nettype none

module hwfm_dp #(
  parameter int FRAME_SIZE = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire hwfm_pkg::hwfm_cmd_t                    cmd,
  output hwfm_pkg::hwfm_status_t                      status,
  input  wire logic [$clog2(FRAME_SIZE)-1:0]          cnt,
  input  wire logic [$clog2(FRAME_SIZE)-1:0]          addr_a,
  input  wire logic [$clog2(FRAME_SIZE)-1:0]          addr_b,
  input  wire logic [$clog2(FRAME_SIZE)-2:0]          tw_addr,
  input  wire logic signed [hwfm_pkg::SAMPLE_W-1:0]   in_sample,
  output logic [hwfm_pkg::BIN_W-1:0]                  out_bin_index,
  output logic [hwfm_pkg::MAG_W-1:0]                  out_magnitude,
  output logic                                        out_last_bin
);

  localparam int AW = $clog2(FRAME_SIZE);
  localparam int WW = hwfm_pkg::WORK_W;
  localparam int TW = hwfm_pkg::TW_W;
  localparam longint HANN_DEN  = longint'(FRAME_SIZE - 1);
  localparam longint HANN_HALF = longint'((FRAME_SIZE - 1) / 2);
  localparam int TW_SHIFT = 32 - AW;

  typedef logic [hwfm_pkg::HANN_W-1:0] hann_tab_t [FRAME_SIZE];
  typedef logic [2*TW-1:0] tw_tab_t [FRAME_SIZE/2];

  function automatic hann_tab_t build_hann();
    hann_tab_t   tab;
    logic [31:0] t;
    longint      h;
    int          i;
    for (i = 0; i < FRAME_SIZE; i++) begin
      t = 32'(((longint'(i) <<< 32) + HANN_HALF) / HANN_DEN);
      h = (hwfm_pkg::ONE_Q30 - hwfm_pkg::cos_turn(t) + 64'sd32768) >>> 16;
      tab[i] = hwfm_pkg::clamp_hann(h);
    end
    return tab;
  endfunction

  function automatic tw_tab_t build_tw();
    tw_tab_t     tab;
    logic [31:0] t;
    int          i;
    for (i = 0; i < FRAME_SIZE/2; i++) begin
      t = 32'(longint'(i) <<< TW_SHIFT);
      tab[i] = {hwfm_pkg::clamp_tw(hwfm_pkg::q30_to_q17(hwfm_pkg::cos_turn(t))),
                hwfm_pkg::clamp_tw(-hwfm_pkg::q30_to_q17(
                  hwfm_pkg::cos_turn(t - 32'h4000_0000)))};
    end
    return tab;
  endfunction

  localparam hann_tab_t HANN_TAB = build_hann();
  localparam tw_tab_t   TW_TAB   = build_tw();

  logic signed [hwfm_pkg::SAMPLE_W-1:0] smp_mem  [FRAME_SIZE];
  logic [hwfm_pkg::MAG_W-1:0]           spec_mem [FRAME_SIZE];
  logic [2*WW-1:0]                      work_mem [FRAME_SIZE];

  // window pipeline
  logic                                 win_v1_r;
  logic                                 win_v2_r;
  logic [AW-1:0]                        win_a1_r;
  logic [AW-1:0]                        win_a2_r;
  logic signed [hwfm_pkg::SAMPLE_W-1:0] smp_rd_r;
  logic [hwfm_pkg::HANN_W-1:0]          hann_r;
  logic signed [31:0]                   prod_r;
  logic signed [31:0]                   win_sum;
  logic [AW-1:0]                        rev_addr;

  // butterfly and magnitude
  logic [2*WW-1:0]                      rd_a_r;
  logic [2*WW-1:0]                      rd_b_r;
  logic [2*TW-1:0]                      tw_r;
  logic signed [WW+TW-1:0]              p_rr_r;
  logic signed [WW+TW-1:0]              p_ii_r;
  logic signed [WW+TW-1:0]              p_ri_r;
  logic signed [WW+TW-1:0]              p_ir_r;
  logic signed [WW+TW:0]                s_re;
  logic signed [WW+TW:0]                s_im;
  logic signed [WW+1:0]                 vr_r;
  logic signed [WW+1:0]                 vi_r;
  logic signed [WW-1:0]                 ur;
  logic signed [WW-1:0]                 ui;
  logic signed [WW-1:0]                 br;
  logic signed [WW-1:0]                 bi;
  logic signed [TW-1:0]                 twr;
  logic signed [TW-1:0]                 twi;
  logic signed [WW+2:0]                 sum_re;
  logic signed [WW+2:0]                 sum_im;
  logic signed [WW+2:0]                 dif_re;
  logic signed [WW+2:0]                 dif_im;
  logic [2*WW-1:0]                      res_a_r;
  logic [2*WW-1:0]                      res_b_r;
  logic signed [2*WW-1:0]               sq_re_r;
  logic signed [2*WW-1:0]               sq_im_r;
  logic [hwfm_pkg::SQ_W-1:0]            sqrt_operand;
  logic [hwfm_pkg::ROOT_W-1:0]          sqrt_root;
  logic [hwfm_pkg::MAG_W-1:0]           mag_sat;

  logic                                 work_we;
  logic [AW-1:0]                        work_wa;
  logic [2*WW-1:0]                      work_wd;

  logic [AW+hwfm_pkg::BIN_W-1:0]        bin_ext;
  logic [hwfm_pkg::BIN_W-1:0]           out_bin_r;
  logic [hwfm_pkg::MAG_W-1:0]           out_mag_r;
  logic                                 out_last_r;

  assign out_bin_index = out_bin_r;
  assign out_magnitude = out_mag_r;
  assign out_last_bin  = out_last_r;
  assign bin_ext       = {{hwfm_pkg::BIN_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (cmd.smp_wr) smp_mem[cnt] <= in_sample;
    if (cmd.win_rd) begin
      smp_rd_r <= smp_mem[addr_a];
      hann_r   <= HANN_TAB[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_v1_r <= 1'b0;
      win_v2_r <= 1'b0;
    end else begin
      win_v1_r <= cmd.win_rd;
      win_v2_r <= win_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_rd) win_a1_r <= addr_a;
    if (win_v1_r) begin
      prod_r   <= smp_rd_r * $signed(hann_r);
      win_a2_r <= win_a1_r;
    end
  end

  assign win_sum = prod_r + 32'sd16384;

  always_comb begin
    for (int i = 0; i < AW; i++) rev_addr[i] = win_a2_r[AW-1-i];
  end

  // windowed samples land bit-reversed; butterflies write a, then b
  always_comb begin
    work_we = win_v2_r | cmd.wr_a | cmd.wr_b;
    priority if (win_v2_r) begin
      work_wa = rev_addr;
      work_wd = {{(WW-17){win_sum[31]}}, win_sum[31:15], {WW{1'b0}}};
    end else if (cmd.wr_a) begin
      work_wa = addr_a;
      work_wd = res_a_r;
    end else begin
      work_wa = addr_b;
      work_wd = res_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (cmd.work_rd) begin
      rd_a_r <= work_mem[addr_a];
      rd_b_r <= work_mem[addr_b];
      tw_r   <= TW_TAB[tw_addr];
    end
  end

  assign ur  = rd_a_r[2*WW-1:WW];
  assign ui  = rd_a_r[WW-1:0];
  assign br  = rd_b_r[2*WW-1:WW];
  assign bi  = rd_b_r[WW-1:0];
  assign twr = tw_r[2*TW-1:TW];
  assign twi = tw_r[TW-1:0];

  assign s_re = (WW+TW+1)'(p_rr_r) - (WW+TW+1)'(p_ii_r) + (WW+TW+1)'(65536);
  assign s_im = (WW+TW+1)'(p_ri_r) + (WW+TW+1)'(p_ir_r) + (WW+TW+1)'(65536);

  assign sum_re = (WW+3)'(ur) + (WW+3)'(vr_r);
  assign sum_im = (WW+3)'(ui) + (WW+3)'(vi_r);
  assign dif_re = (WW+3)'(ur) - (WW+3)'(vr_r);
  assign dif_im = (WW+3)'(ui) - (WW+3)'(vi_r);

  always_ff @(posedge clk) begin
    if (cmd.bf_mul) begin
      p_rr_r <= br * twr;
      p_ii_r <= bi * twi;
      p_ri_r <= br * twi;
      p_ir_r <= bi * twr;
    end
    if (cmd.bf_sum) begin
      vr_r <= s_re[WW+TW:17];
      vi_r <= s_im[WW+TW:17];
    end
    if (cmd.bf_add) begin
      res_a_r <= {hwfm_pkg::sat_work(sum_re), hwfm_pkg::sat_work(sum_im)};
      res_b_r <= {hwfm_pkg::sat_work(dif_re), hwfm_pkg::sat_work(dif_im)};
    end
    if (cmd.mag_sq) begin
      sq_re_r <= ur * ur;
      sq_im_r <= ui * ui;
    end
  end

  assign sqrt_operand = {1'b0, sq_re_r} + {1'b0, sq_im_r};

  hwfm_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (sqrt_operand),
    .busy    (status.sqrt_busy),
    .root    (sqrt_root)
  );

  assign mag_sat = (sqrt_root > hwfm_pkg::ROOT_W'(hwfm_pkg::MAG_MAX)) ?
                   hwfm_pkg::MAG_MAX : sqrt_root[hwfm_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.spec_wr) spec_mem[addr_a] <= mag_sat;
    if (cmd.out_load) begin
      out_mag_r  <= spec_mem[cnt];
      out_bin_r  <= bin_ext[hwfm_pkg::BIN_W-1:0];
      out_last_r <= (cnt == AW'(FRAME_SIZE - 1));
    end
  end

endmodule

`default_nettype wire

// File: src/hwfm_ctrl.sv
`default_nettype none

module hwfm_ctrl #(
  parameter int FRAME_SIZE = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output hwfm_pkg::hwfm_cmd_t                    cmd,
  input  wire hwfm_pkg::hwfm_status_t            status,
  output logic [$clog2(FRAME_SIZE)-1:0]          cnt,
  output logic [$clog2(FRAME_SIZE)-1:0]          addr_a,
  output logic [$clog2(FRAME_SIZE)-1:0]          addr_b,
  output logic [$clog2(FRAME_SIZE)-2:0]          tw_addr
);

  localparam int AW = $clog2(FRAME_SIZE);
  localparam int SW = $clog2(AW);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_SIZE - 1);
  localparam logic [SW-1:0] LAST_STAGE = SW'(AW - 1);

  typedef enum logic [3:0] {
    S_LOAD, S_WIN, S_WIN_DR1, S_WIN_DR2, S_BF,
    S_MAG_RD, S_MAG_SQ, S_MAG_SUM, S_MAG_WAIT, S_MAG_WR
  } state_t;

  typedef enum logic [2:0] {
    BF_RD, BF_MUL, BF_SUM, BF_ADD, BF_WR_A, BF_WR_B
  } bf_step_t;

  state_t        state_r;
  bf_step_t      step_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic [SW-1:0] stage_r;
  logic          frame_ready_r;
  logic          out_valid_r;
  logic          accept;

  logic [AW-1:0] mask;
  logic [AW-1:0] bcnt;
  logic [AW-1:0] lo;
  logic [AW-1:0] bf_a;
  logic [AW-1:0] tw_full;
  logic [SW-1:0] tw_sh;

  assign in_stall  = (state_r != S_LOAD) | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

  // butterfly index with a zero inserted at the stage bit gives the upper leg
  assign mask    = (AW'(1) << stage_r) - AW'(1);
  assign bcnt    = {1'b0, idx_r[AW-2:0]};
  assign lo      = bcnt & mask;
  assign bf_a    = ((bcnt & ~mask) << 1) | lo;
  assign tw_sh   = LAST_STAGE - stage_r;
  assign tw_full = lo << tw_sh;
  assign addr_a  = (state_r == S_BF) ? bf_a : idx_r;
  assign addr_b  = bf_a | (AW'(1) << stage_r);
  assign tw_addr = tw_full[AW-2:0];

  always_comb begin
    cmd            = '0;
    cmd.smp_wr     = accept;
    cmd.out_load   = accept & frame_ready_r;
    cmd.win_rd     = (state_r == S_WIN);
    cmd.work_rd    = ((state_r == S_BF) && (step_r == BF_RD)) || (state_r == S_MAG_RD);
    cmd.bf_mul     = (state_r == S_BF) && (step_r == BF_MUL);
    cmd.bf_sum     = (state_r == S_BF) && (step_r == BF_SUM);
    cmd.bf_add     = (state_r == S_BF) && (step_r == BF_ADD);
    cmd.wr_a       = (state_r == S_BF) && (step_r == BF_WR_A);
    cmd.wr_b       = (state_r == S_BF) && (step_r == BF_WR_B);
    cmd.mag_sq     = (state_r == S_MAG_SQ);
    cmd.sqrt_start = (state_r == S_MAG_SUM);
    cmd.spec_wr    = (state_r == S_MAG_WR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      step_r        <= BF_RD;
      cnt_r         <= '0;
      idx_r         <= '0;
      stage_r       <= '0;
      frame_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept && frame_ready_r) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (cnt_r == LAST_IDX) begin
              cnt_r   <= '0;
              idx_r   <= '0;
              state_r <= S_WIN;
            end else begin
              cnt_r <= cnt_r + AW'(1);
            end
          end
        end
        S_WIN: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == LAST_IDX) state_r <= S_WIN_DR1;
        end
        S_WIN_DR1: state_r <= S_WIN_DR2;
        S_WIN_DR2: begin
          state_r <= S_BF;
          step_r  <= BF_RD;
          idx_r   <= '0;
          stage_r <= '0;
        end
        S_BF: begin
          unique case (step_r)
            BF_RD:   step_r <= BF_MUL;
            BF_MUL:  step_r <= BF_SUM;
            BF_SUM:  step_r <= BF_ADD;
            BF_ADD:  step_r <= BF_WR_A;
            BF_WR_A: step_r <= BF_WR_B;
            BF_WR_B: begin
              step_r <= BF_RD;
              if (&idx_r[AW-2:0]) begin
                idx_r <= '0;
                if (stage_r == LAST_STAGE) state_r <= S_MAG_RD;
                else stage_r <= stage_r + SW'(1);
              end else begin
                idx_r <= idx_r + AW'(1);
              end
            end
            default: step_r <= BF_RD;
          endcase
        end
        S_MAG_RD:  state_r <= S_MAG_SQ;
        S_MAG_SQ:  state_r <= S_MAG_SUM;
        S_MAG_SUM: state_r <= S_MAG_WAIT;
        S_MAG_WAIT: begin
          if (!status.sqrt_busy) state_r <= S_MAG_WR;
        end
        S_MAG_WR: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == LAST_IDX) begin
            state_r       <= S_LOAD;
            frame_ready_r <= 1'b1;
          end else begin
            state_r <= S_MAG_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an accepted item");

  a_cnt_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (cnt_r == '0))
    else $error("sample count not cleared while frame is processed");

  a_sqrt_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.sqrt_busy |-> (state_r == S_MAG_WAIT))
    else $error("square root running outside its wait state");

endmodule

`default_nettype wire

// File: src/hann_windowed_fft_magnitude_unit.sv
// While a frame loads, one sample is accepted per cycle; its bin leaves from an output
// register in the next cycle (from the second frame on), and the input waits only while
// that register is stalled. The last sample of a frame holds the input while the frame
// is windowed, transformed by a butterfly unit (read, multiply, sum, add, write a, write
// b) and reduced to magnitudes by a square root unit that settles one bit per cycle.
// Synchronous active-low reset clears the control state; memories are not cleared.
`default_nettype none

module hann_windowed_fft_magnitude_unit #(
  parameter int FRAME_SIZE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [hwfm_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [hwfm_pkg::BIN_W-1:0]                 out_bin_index,
  output logic [hwfm_pkg::MAG_W-1:0]                 out_magnitude,
  output logic                                       out_last_bin
);

  localparam int AW = $clog2(FRAME_SIZE);

  hwfm_pkg::hwfm_cmd_t    cmd;
  hwfm_pkg::hwfm_status_t status;
  logic [AW-1:0]          cnt;
  logic [AW-1:0]          addr_a;
  logic [AW-1:0]          addr_b;
  logic [AW-2:0]          tw_addr;

  hwfm_ctrl #(.FRAME_SIZE(FRAME_SIZE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .cnt       (cnt),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .tw_addr   (tw_addr)
  );

  hwfm_dp #(.FRAME_SIZE(FRAME_SIZE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cnt           (cnt),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .tw_addr       (tw_addr),
    .in_sample     (in_sample),
    .out_bin_index (out_bin_index),
    .out_magnitude (out_magnitude),
    .out_last_bin  (out_last_bin)
  );

endmodule

`default_nettype wire
